[design/tts_pkg.sv]
// Package with shared constants, types and helper functions for the tick-to-ns scale block.
package tts_pkg;

  localparam logic [63:0] TargetRate = 64'd1000000000;
  localparam int YLimitBits = 31;
  localparam int FracBits = 32;
  localparam int DivSteps = 32;

  typedef struct packed {
    logic [30:0]        rem;
    logic [31:0]        xlo;
    logic [30:0]        y;
    logic [31:0]        quo;
    logic signed [7:0]  expo;
    logic               bad;
  } div_t;

  function automatic logic [6:0] bit_len64(input logic [63:0] v);
    logic [6:0] n;
    n = 7'd0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) begin
        n = 7'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

[design/tts_norm.sv]
// Four-stage normalization front end that prepares dividend, divisor and exponent.
module tts_norm (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [63:0]      freq,
  output logic             out_valid,
  output tts_pkg::div_t    out_data
);
  import tts_pkg::*;

  logic              a_v_r, b_v_r, c_v_r, d_v_r;
  logic [63:0]       a_freq_r;
  logic [6:0]        a_bl_r;
  logic [30:0]       b_y_r, c_y_r;
  logic signed [7:0] b_e_r, c_e_r;
  logic              b_bad_r, c_bad_r;
  logic [4:0]        c_bl_r;
  div_t              d_data_r;

  logic [6:0]        s1;
  logic [63:0]       y_sh;
  logic [6:0]        c_bl_full;
  logic [5:0]        k1;
  logic [63:0]       xa, tgt, xsel;
  logic signed [7:0] e_nxt;
  div_t              d_data_nxt;

  always_comb begin
    s1 = (a_bl_r > 7'(YLimitBits)) ? (a_bl_r - 7'(YLimitBits)) : 7'd0;
    y_sh = a_freq_r >> s1;
    c_bl_full = bit_len64({33'd0, b_y_r});
    k1 = {1'b0, c_bl_r} + 6'd1;
    xa = TargetRate << k1;
    tgt = {2'b00, c_y_r, 31'd0};
    if (xa >= tgt) begin
      xsel = xa;
      e_nxt = c_e_r - 8'(k1);
    end else begin
      xsel = xa << 1;
      e_nxt = c_e_r - 8'(k1) - 8'sd1;
    end
    d_data_nxt.rem = xsel[62:32];
    d_data_nxt.xlo = xsel[31:0];
    d_data_nxt.y = c_y_r;
    d_data_nxt.quo = 32'd0;
    d_data_nxt.expo = e_nxt;
    d_data_nxt.bad = c_bad_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_freq_r <= freq;
      a_bl_r <= bit_len64(freq);
      b_y_r <= y_sh[30:0];
      b_e_r <= 8'sd32 - 8'(s1);
      b_bad_r <= (a_freq_r == 64'd0);
      c_y_r <= b_y_r;
      c_e_r <= b_e_r;
      c_bad_r <= b_bad_r;
      c_bl_r <= c_bl_full[4:0];
      d_data_r <= d_data_nxt;
    end
  end

  assign out_valid = d_v_r;
  assign out_data = d_data_r;
endmodule

[design/tts_div_stage.sv]
// One registered restoring-division step producing one quotient bit.
module tts_div_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  tts_pkg::div_t    in_data,
  output logic             out_valid,
  output tts_pkg::div_t    out_data
);
  import tts_pkg::*;

  logic  v_r;
  div_t  data_r;
  div_t  data_nxt;
  logic [31:0] trial;

  always_comb begin
    data_nxt = in_data;
    trial = {in_data.rem, in_data.xlo[31]};
    data_nxt.xlo = {in_data.xlo[30:0], 1'b0};
    if (trial >= {1'b0, in_data.y}) begin
      trial = trial - {1'b0, in_data.y};
      data_nxt.quo = {in_data.quo[30:0], 1'b1};
    end else begin
      data_nxt.quo = {in_data.quo[30:0], 1'b0};
    end
    data_nxt.rem = trial[30:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data = data_r;
endmodule

[design/tick_to_ns_scale_factor_core.sv]
// Top level: tick frequency to nanosecond multiplier and shift, fully pipelined.
// The pipeline has four normalization stages and 32 division steps.
// A new beat is taken every cycle; the whole pipeline stalls together when
// the output beat waits, so nothing is lost or repeated.
// Synchronous active-low reset clears all valid bits; data registers are not reset.
module tick_to_ns_scale_factor_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_tick_frequency,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_multiplier,
  output logic signed [6:0] out_shift,
  output logic        out_bad_frequency
);
  import tts_pkg::*;

  logic en;
  logic [DivSteps:0] v;
  div_t d [DivSteps+1];

  assign en = !v[DivSteps] || out_ready;
  assign in_ready = en;

  tts_norm u_norm (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
    .freq(in_tick_frequency), .out_valid(v[0]), .out_data(d[0])
  );

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    tts_div_stage u_stage (
      .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v[i]), .in_data(d[i]),
      .out_valid(v[i+1]), .out_data(d[i+1])
    );
  end

  assign out_valid = v[DivSteps];
  assign out_bad_frequency = d[DivSteps].bad;
  assign out_multiplier = d[DivSteps].bad ? 32'd0 : d[DivSteps].quo;
  assign out_shift = d[DivSteps].bad ? 7'sd0 : d[DivSteps].expo[6:0];

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow the output stall");
  a_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_frequency |-> out_multiplier == 32'd0 && out_shift == 7'sd0)
    else $error("bad frequency result is not zero");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");
endmodule

[test/tick_to_ns_scale_factor_checker.sv]
// Checker that predicts each scale-factor result from the accepted input beats and compares.
module tick_to_ns_scale_factor_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [63:0] in_tick_frequency,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_multiplier,
  input  logic signed [6:0] out_shift,
  input  logic        out_bad_frequency,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [31:0] mul;
    logic [6:0]  shift;
    logic        bad;
  } scale_t;

  scale_t scale_q[$];

  function automatic scale_t predict_scale(input logic [63:0] freq);
    scale_t r;
    logic [63:0] x;
    logic [63:0] y;
    int e;
    int guard;
    r = '0;
    if (freq == 64'd0) begin
      r.bad = 1'b1;
      return r;
    end
    e = tts_pkg::FracBits;
    x = tts_pkg::TargetRate;
    y = freq;
    while (y >= (64'd1 << tts_pkg::YLimitBits)) begin
      y = y >> 1;
      e--;
    end
    while (x < (y << tts_pkg::YLimitBits) && !x[63]) begin
      x = x << 1;
      e--;
    end
    while (y != 64'd0 && x < y) begin
      y = y >> 1;
      e++;
    end
    guard = 0;
    while (y != 64'd0 && x >= (y << tts_pkg::FracBits) && guard < 64) begin
      x = x >> 1;
      e++;
      guard++;
    end
    r.mul = (y == 64'd0) ? 32'hFFFFFFFF : 32'(x / y);
    r.shift = 7'(e);
    return r;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    scale_t w;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        scale_q.push_back(predict_scale(in_tick_frequency));
      end
      if (out_valid && out_ready) begin
        if (scale_q.size() == 0) begin
          report("unexpected beat", 64'(out_multiplier), 64'd0);
        end else begin
          w = scale_q.pop_front();
          if (out_multiplier !== w.mul) report("multiplier", 64'(out_multiplier), 64'(w.mul));
          if (out_shift !== w.shift) report("shift", 64'(out_shift), 64'(w.shift));
          if (out_bad_frequency !== w.bad) begin
            report("bad_frequency", 64'(out_bad_frequency), 64'(w.bad));
          end
        end
      end
    end
    pending = scale_q.size();
  end

endmodule

[test/tb_tick_to_ns_scale_factor_core.sv]
// Testbench top: drives random and directed frequencies with random stalls and gives the verdict.
module tb_tick_to_ns_scale_factor_core;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_tick_frequency = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_multiplier;
  logic signed [6:0] out_shift;
  logic        out_bad_frequency;
  int          errors;
  int          pending;
  logic [63:0] freq_list[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  tick_to_ns_scale_factor_core dut (.*);

  tick_to_ns_scale_factor_checker checker_i (.*);

  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (out_ready && out_valid || !out_ready) begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
          if (gap == 0) begin
            out_ready <= 1'b1;
          end else begin
            out_ready <= 1'b0;
            repeat (gap) @(posedge clk);
            out_ready <= 1'b1;
          end
        end
      end
    end
  end

  function automatic logic [63:0] rand_freq();
    logic [63:0] v;
    int k;
    v = {$urandom(), $urandom()};
    case ($urandom_range(0, 3))
      0: k = $urandom_range(1, 64);
      1: k = $urandom_range(20, 40);
      default: k = 64;
    endcase
    if (k < 64) v = v & ((64'd1 << k) - 64'd1);
    if ($urandom_range(0, 50) == 0) v = 64'd0;
    return v;
  endfunction

  initial begin
    int gap;
    freq_list = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd1000000000, 64'd999999999,
                  64'd1000000001, 64'h7FFFFFFF, 64'h80000000, 64'hFFFFFFFF,
                  64'h100000000, 64'd19200000, 64'd24000000, 64'd2400000000,
                  64'hFFFFFFFFFFFFFFFF, 64'h8000000000000000, 64'h7FFFFFFFFFFFFFFF,
                  64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA, 64'd32768};
    repeat (1850) freq_list.push_back(rand_freq());
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    foreach (freq_list[i]) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_tick_frequency <= freq_list[i];
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
